// File: hw/rtl/brcp_pkg.sv
// Shared types, constants and the microcode program of the cascaded PID core.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package brcp_pkg;

  localparam int unsigned NumGains = 7;
  localparam int unsigned GainW    = 32;
  localparam int unsigned LimitW   = 31;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned FieldW   = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned ErrW     = 33;
  localparam int unsigned IntW     = 48;
  localparam int unsigned OpW      = 48;
  localparam int unsigned HalfW    = 16;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned TermW    = 80;
  localparam int unsigned AccW     = 50;
  localparam int unsigned PerrW    = 40;
  localparam int unsigned NumSteps = 27;
  localparam int unsigned PcW      = 5;

  localparam logic signed [ErrW-1:0] SpeedBand = 33'sd65536;
  localparam logic signed [ErrW-1:0] YawBand   = 33'sd655360;

  typedef enum logic [RegIdxW-1:0] {
    REG_SPEED_KP       = 3'd0,
    REG_SPEED_KI       = 3'd1,
    REG_PITCH_KP       = 3'd2,
    REG_PITCH_KD       = 3'd3,
    REG_STEER_KP       = 3'd4,
    REG_STEER_KI       = 3'd5,
    REG_STEER_KD       = 3'd6,
    REG_INTEGRAL_LIMIT = 3'd7
  } reg_e;

  localparam logic [NumGains-1:0][GainW-1:0] GainReset = {
    32'd10737418, 32'd26844, 32'd268435, 32'd134217728,
    32'd13421773, 32'd13421773, 32'd80530637
  };
  localparam logic [LimitW-1:0] LimitReset = 31'd65536;

  typedef struct packed {
    logic signed [FieldW-1:0] yaw_rate;
    logic signed [FieldW-1:0] target_yaw;
    logic signed [FieldW-1:0] yaw_angle;
    logic signed [FieldW-1:0] pitch_rate;
    logic signed [FieldW-1:0] pitch_angle;
    logic signed [FieldW-1:0] right_wheel_speed;
    logic signed [FieldW-1:0] left_wheel_speed;
    logic signed [FieldW-1:0] target_speed;
  } in_t;

  typedef struct packed {
    logic [NumGains-1:0][GainW-1:0] gain;
    logic [LimitW-1:0]              limit;
  } cfg_t;

  typedef enum logic [2:0] {
    A_VERR  = 3'd0,
    A_YERR  = 3'd1,
    A_SINT  = 3'd2,
    A_YINT  = 3'd3,
    A_PERR  = 3'd4,
    A_PRATE = 3'd5,
    A_YRATE = 3'd6
  } a_sel_e;

  typedef enum logic {
    H_LO = 1'b0,
    H_HI = 1'b1
  } half_e;

  typedef enum logic [1:0] {
    T_NONE = 2'd0,
    T_LOAD = 2'd1,
    T_MAC  = 2'd2
  } t_op_e;

  typedef enum logic [2:0] {
    ACC_NONE = 3'd0,
    ACC_ZERO = 3'd1,
    ACC_ACC  = 3'd2,
    ACC_SINT = 3'd3,
    ACC_YINT = 3'd4
  } acc_op_e;

  typedef enum logic [1:0] {
    SH_12 = 2'd0,
    SH_28 = 2'd1,
    SH_44 = 2'd2
  } shift_e;

  typedef enum logic [2:0] {
    WB_NONE = 3'd0,
    WB_PREP = 3'd1,
    WB_SINT = 3'd2,
    WB_YINT = 3'd3,
    WB_PERR = 3'd4,
    WB_PWM  = 3'd5,
    WB_OUT  = 3'd6
  } wb_e;

  typedef enum logic [1:0] {
    J_NONE     = 2'd0,
    J_NO_SBAND = 2'd1,
    J_NO_YBAND = 2'd2,
    J_WAIT_OUT = 2'd3
  } jmp_e;

  typedef struct packed {
    a_sel_e         a_sel;
    reg_e           g_sel;
    half_e          half;
    t_op_e          t_op;
    acc_op_e        acc_op;
    shift_e         shift;
    wb_e            wb;
    jmp_e           jmp;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic sband;
    logic yband;
  } status_t;

  localparam logic [PcW-1:0] StepPrep   = PcW'(0);
  localparam logic [PcW-1:0] StepSintWb = PcW'(5);
  localparam logic [PcW-1:0] StepYintWb = PcW'(9);
  localparam logic [PcW-1:0] StepOut    = PcW'(26);

  localparam ctrl_t CtrlNop =
    '{A_VERR, REG_SPEED_KP, H_LO, T_NONE, ACC_NONE, SH_12, WB_NONE, J_NONE, StepPrep};

  // Multiply, term build and accumulation overlap, linked by p_q and t_q.
  localparam ctrl_t Program [NumSteps] = '{
    '{A_VERR,  REG_SPEED_KP, H_LO, T_NONE, ACC_NONE, SH_12, WB_PREP, J_NONE,     StepPrep},
    '{A_VERR,  REG_SPEED_KI, H_HI, T_NONE, ACC_NONE, SH_12, WB_NONE, J_NO_SBAND, StepSintWb},
    '{A_VERR,  REG_SPEED_KI, H_LO, T_LOAD, ACC_NONE, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_VERR,  REG_SPEED_KI, H_LO, T_MAC,  ACC_NONE, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_VERR,  REG_SPEED_KI, H_LO, T_NONE, ACC_SINT, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_YERR,  REG_STEER_KI, H_HI, T_NONE, ACC_NONE, SH_12, WB_SINT, J_NO_YBAND, StepYintWb},
    '{A_YERR,  REG_STEER_KI, H_LO, T_LOAD, ACC_NONE, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_YERR,  REG_STEER_KI, H_LO, T_MAC,  ACC_NONE, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_YERR,  REG_STEER_KI, H_LO, T_NONE, ACC_YINT, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_VERR,  REG_SPEED_KP, H_HI, T_NONE, ACC_NONE, SH_12, WB_YINT, J_NONE,     StepPrep},
    '{A_VERR,  REG_SPEED_KP, H_LO, T_LOAD, ACC_NONE, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_SINT,  REG_SPEED_KI, H_HI, T_MAC,  ACC_NONE, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_SINT,  REG_SPEED_KI, H_LO, T_LOAD, ACC_ZERO, SH_28, WB_NONE, J_NONE,     StepPrep},
    '{A_PRATE, REG_PITCH_KD, H_HI, T_MAC,  ACC_NONE, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_PRATE, REG_PITCH_KD, H_LO, T_LOAD, ACC_ACC,  SH_44, WB_NONE, J_NONE,     StepPrep},
    '{A_PRATE, REG_PITCH_KD, H_LO, T_MAC,  ACC_NONE, SH_12, WB_PERR, J_NONE,     StepPrep},
    '{A_PERR,  REG_PITCH_KP, H_HI, T_NONE, ACC_ZERO, SH_28, WB_NONE, J_NONE,     StepPrep},
    '{A_PERR,  REG_PITCH_KP, H_LO, T_LOAD, ACC_NONE, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_YERR,  REG_STEER_KP, H_HI, T_MAC,  ACC_NONE, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_YERR,  REG_STEER_KP, H_LO, T_LOAD, ACC_ACC,  SH_28, WB_NONE, J_NONE,     StepPrep},
    '{A_YINT,  REG_STEER_KI, H_HI, T_MAC,  ACC_NONE, SH_12, WB_PWM,  J_NONE,     StepPrep},
    '{A_YINT,  REG_STEER_KI, H_LO, T_LOAD, ACC_ZERO, SH_28, WB_NONE, J_NONE,     StepPrep},
    '{A_YRATE, REG_STEER_KD, H_HI, T_MAC,  ACC_NONE, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_YRATE, REG_STEER_KD, H_LO, T_LOAD, ACC_ACC,  SH_44, WB_NONE, J_NONE,     StepPrep},
    '{A_YRATE, REG_STEER_KD, H_LO, T_MAC,  ACC_NONE, SH_12, WB_NONE, J_NONE,     StepPrep},
    '{A_YRATE, REG_STEER_KD, H_LO, T_NONE, ACC_ACC,  SH_28, WB_NONE, J_NONE,     StepPrep},
    '{A_YRATE, REG_STEER_KD, H_LO, T_NONE, ACC_NONE, SH_12, WB_OUT,  J_WAIT_OUT, StepOut}
  };

endpackage

// File: hw/rtl/brcp_sequencer.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on brcp_pkg for the control word, status flags and the program.
module brcp_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  brcp_pkg::status_t status_i,
  input  logic              out_full_i,
  output logic              busy_o,
  output brcp_pkg::ctrl_t   ctrl_o
);

  logic                     busy_q, busy_d;
  logic [brcp_pkg::PcW-1:0] pc_q, pc_d;
  brcp_pkg::ctrl_t          cw;
  logic                     stall;
  logic                     taken;

  assign cw    = brcp_pkg::Program[pc_q];
  assign stall = (cw.jmp == brcp_pkg::J_WAIT_OUT) && out_full_i;

  always_comb begin
    case (cw.jmp)
      brcp_pkg::J_NO_SBAND: taken = !status_i.sband;
      brcp_pkg::J_NO_YBAND: taken = !status_i.yband;
      brcp_pkg::J_WAIT_OUT: taken = stall;
      default:              taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = brcp_pkg::StepPrep;
    end else if (busy_q) begin
      if (taken) begin
        pc_d = cw.target;
      end else if (cw.jmp == brcp_pkg::J_WAIT_OUT) begin
        busy_d = 1'b0;
        pc_d   = brcp_pkg::StepPrep;
      end else begin
        pc_d = pc_q + brcp_pkg::PcW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= brcp_pkg::StepPrep;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign busy_o = busy_q;
  assign ctrl_o = (busy_q && !stall) ? cw : brcp_pkg::CtrlNop;

`ifndef ASSERT_OFF
  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < brcp_pkg::PcW'(brcp_pkg::NumSteps))
    else $error("Step counter has left the program.");

  a_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (pc_q == brcp_pkg::StepPrep))
    else $error("Idle sequencer is not parked on the first step.");
`endif

endmodule

// File: hw/rtl/brcp_datapath.sv
// Datapath of the cascaded PID core: shared multiplier, term and sum registers,
// integrators with band, clamp and clearing, and torque saturation. Uses brcp_pkg.
module brcp_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_load_i,
  input  brcp_pkg::in_t                          in_i,
  input  brcp_pkg::cfg_t                         cfg_i,
  input  brcp_pkg::ctrl_t                        ctrl_i,
  output brcp_pkg::status_t                      status_o,
  output logic signed [brcp_pkg::FieldW-1:0]     left_o,
  output logic signed [brcp_pkg::FieldW-1:0]     right_o
);

  localparam int unsigned AccW = brcp_pkg::AccW;
  localparam int unsigned IntW = brcp_pkg::IntW;
  localparam int unsigned ErrW = brcp_pkg::ErrW;
  localparam int unsigned FieldW = brcp_pkg::FieldW;
  localparam logic signed [AccW:0] SatHi = $signed((AccW+1)'(32'h7fff_ffff));
  localparam logic signed [AccW:0] SatLo = -SatHi - (AccW+1)'(1);

  brcp_pkg::in_t                          in_q;
  logic signed [ErrW-1:0]                 verr_q, verr_d, yerr_q, yerr_d;
  logic signed [IntW-1:0]                 sint_q, sint_d, yint_q, yint_d;
  logic signed [brcp_pkg::PerrW-1:0]      perr_q, perr_d;
  logic signed [AccW-1:0]                 pwm_q, pwm_d, acc_q, acc_d;
  logic signed [brcp_pkg::ProdW-1:0]      p_q, prod;
  logic signed [brcp_pkg::TermW-1:0]      t_q, t_d, t_sh;
  logic signed [brcp_pkg::OpW-1:0]        op_a;
  logic [brcp_pkg::GainW-1:0]             gain;
  logic [brcp_pkg::HalfW-1:0]             half;
  logic signed [AccW-1:0]                 acc_add, lim;
  logic signed [ErrW-1:0]                 wheel_sum;
  logic signed [FieldW-1:0]               wheel_avg;
  logic signed [AccW:0]                   sum_l, sum_r;

  function automatic logic signed [IntW-1:0] clamp_int(input logic signed [AccW-1:0] v,
                                                       input logic signed [AccW-1:0] l);
    logic signed [AccW-1:0] nl;
    nl = -l;
    if (v > l) begin
      return l[IntW-1:0];
    end else if (v < nl) begin
      return nl[IntW-1:0];
    end
    return v[IntW-1:0];
  endfunction

  function automatic logic signed [FieldW-1:0] sat_word(input logic signed [AccW:0] v);
    if (v > SatHi) begin
      return SatHi[FieldW-1:0];
    end else if (v < SatLo) begin
      return SatLo[FieldW-1:0];
    end
    return v[FieldW-1:0];
  endfunction

  assign status_o.sband = (verr_q > -brcp_pkg::SpeedBand) && (verr_q < brcp_pkg::SpeedBand);
  assign status_o.yband = (yerr_q > -brcp_pkg::YawBand) && (yerr_q < brcp_pkg::YawBand);

  assign lim = $signed({{(AccW - brcp_pkg::LimitW - brcp_pkg::FracW){1'b0}},
                        cfg_i.limit, {brcp_pkg::FracW{1'b0}}});

  always_comb begin
    case (ctrl_i.a_sel)
      brcp_pkg::A_VERR:  op_a = brcp_pkg::OpW'(verr_q);
      brcp_pkg::A_YERR:  op_a = brcp_pkg::OpW'(yerr_q);
      brcp_pkg::A_SINT:  op_a = brcp_pkg::OpW'(sint_q);
      brcp_pkg::A_YINT:  op_a = brcp_pkg::OpW'(yint_q);
      brcp_pkg::A_PERR:  op_a = brcp_pkg::OpW'(perr_q);
      brcp_pkg::A_PRATE: op_a = brcp_pkg::OpW'($signed(in_q.pitch_rate));
      brcp_pkg::A_YRATE: op_a = brcp_pkg::OpW'($signed(in_q.yaw_rate));
      default:           op_a = '0;
    endcase
  end

  assign gain = cfg_i.gain[ctrl_i.g_sel];
  assign half = (ctrl_i.half == brcp_pkg::H_HI) ? gain[brcp_pkg::GainW-1:brcp_pkg::HalfW]
                                                : gain[brcp_pkg::HalfW-1:0];
  assign prod = op_a * $signed({1'b0, half});

  always_comb begin
    case (ctrl_i.t_op)
      brcp_pkg::T_LOAD: t_d = brcp_pkg::TermW'(p_q);
      brcp_pkg::T_MAC:  t_d = (t_q <<< brcp_pkg::HalfW) + brcp_pkg::TermW'(p_q);
      default:          t_d = t_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.shift)
      brcp_pkg::SH_28: t_sh = t_q >>> 28;
      brcp_pkg::SH_44: t_sh = t_q >>> 44;
      default:         t_sh = t_q >>> 12;
    endcase
  end
  assign acc_add = $signed(t_sh[AccW-1:0]);

  always_comb begin
    case (ctrl_i.acc_op)
      brcp_pkg::ACC_ZERO: acc_d = acc_add;
      brcp_pkg::ACC_ACC:  acc_d = acc_q + acc_add;
      brcp_pkg::ACC_SINT: acc_d = AccW'(sint_q) + acc_add;
      brcp_pkg::ACC_YINT: acc_d = AccW'(yint_q) + acc_add;
      default:            acc_d = acc_q;
    endcase
  end

  assign wheel_sum = ErrW'($signed(in_q.left_wheel_speed))
                   + ErrW'($signed(in_q.right_wheel_speed));
  assign wheel_avg = wheel_sum[ErrW-1:1];

  always_comb begin
    verr_d = verr_q;
    yerr_d = yerr_q;
    sint_d = sint_q;
    yint_d = yint_q;
    perr_d = perr_q;
    pwm_d  = pwm_q;
    case (ctrl_i.wb)
      brcp_pkg::WB_PREP: begin
        verr_d = ErrW'($signed(in_q.target_speed)) - ErrW'(wheel_avg);
        yerr_d = ErrW'($signed(in_q.yaw_angle)) - ErrW'($signed(in_q.target_yaw));
        if (in_q.target_speed == '0) begin
          sint_d = '0;
        end
        if (in_q.target_yaw == '0) begin
          yint_d = '0;
        end
      end
      brcp_pkg::WB_SINT: sint_d = status_o.sband ? clamp_int(acc_q, lim) : '0;
      brcp_pkg::WB_YINT: yint_d = status_o.yband ? clamp_int(acc_q, lim) : '0;
      brcp_pkg::WB_PERR: begin
        perr_d = brcp_pkg::PerrW'($signed(in_q.pitch_angle))
               - $signed(acc_q[brcp_pkg::PerrW-1:0]);
      end
      brcp_pkg::WB_PWM:  pwm_d = acc_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sint_q <= '0;
      yint_q <= '0;
    end else begin
      sint_q <= sint_d;
      yint_q <= yint_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      in_q <= in_i;
    end
    verr_q <= verr_d;
    yerr_q <= yerr_d;
    perr_q <= perr_d;
    pwm_q  <= pwm_d;
    acc_q  <= acc_d;
    p_q    <= prod;
    t_q    <= t_d;
  end

  assign sum_l   = (AccW+1)'(pwm_q) + (AccW+1)'(acc_q);
  assign sum_r   = (AccW+1)'(pwm_q) - (AccW+1)'(acc_q);
  assign left_o  = sat_word(sum_l);
  assign right_o = sat_word(sum_r);

endmodule

// File: hw/rtl/balance_robot_cascade_pid_core.sv
// Cascaded PID balancing controller core: configuration registers, stream
// handshakes and output register around the sequencer and the datapath.
// Depends on brcp_pkg, brcp_sequencer and brcp_datapath.
//
// Use: each input transaction on the s_axis channel carries eight Q16.16 fields
// (speed and yaw targets, wheel speeds, pitch, yaw and their rates). Each one
// yields one output transaction on m_axis with the left and right wheel torque.
// The user must write gains and the integrator limit through the cfg port only while
// the core is idle (not enforced); they take effect on the next input transaction.
// Timing: the input is taken when s_axis_tready_o is high, then a 27-step microcode
// program runs on one shared 48 x 17 bit multiplier (a pass with the high and a pass
// with the low gain half per gain product). Integrator steps are skipped for an error
// outside its band, so the program runs shorter for such an error; a new item is
// accepted only once the program for the previous one has ended.
// Stalls: a finished result waits in the output register; a new item is accepted
// and worked on meanwhile, and the program halts on its last step until the
// previous result has been taken.
// Reset: asynchronous, active low; gains and limit return to their defaults,
// both integrators are cleared and no output is pending.
module balance_robot_cascade_pid_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // target_speed, left_wheel_speed, right_wheel_speed, pitch_angle,
  // pitch_rate, yaw_angle, target_yaw, yaw_rate (32 bits each, lowest first)
  input  logic [$bits(brcp_pkg::in_t)-1:0]       s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // left_torque, right_torque (32 bits each, lowest first)
  output logic [2*brcp_pkg::FieldW-1:0]          m_axis_tdata_o,
  input  logic                                   cfg_we_i,
  input  logic [brcp_pkg::RegIdxW-1:0]           cfg_idx_i,
  input  logic [brcp_pkg::GainW-1:0]             cfg_data_i
);

  localparam int unsigned FieldW = brcp_pkg::FieldW;

  brcp_pkg::cfg_t    cfg_q;
  brcp_pkg::in_t     in_fields;
  brcp_pkg::ctrl_t   ctrl;
  brcp_pkg::status_t status;
  logic              busy;
  logic              in_accept;
  logic              out_load;
  logic              out_valid_q;
  logic [2*FieldW-1:0] out_data_q;
  logic signed [FieldW-1:0] left_torque, right_torque;

  assign s_axis_tready_o = !busy;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (ctrl.wb == brcp_pkg::WB_OUT);

  assign in_fields.target_speed      = s_axis_tdata_i[0*FieldW +: FieldW];
  assign in_fields.left_wheel_speed  = s_axis_tdata_i[1*FieldW +: FieldW];
  assign in_fields.right_wheel_speed = s_axis_tdata_i[2*FieldW +: FieldW];
  assign in_fields.pitch_angle       = s_axis_tdata_i[3*FieldW +: FieldW];
  assign in_fields.pitch_rate        = s_axis_tdata_i[4*FieldW +: FieldW];
  assign in_fields.yaw_angle         = s_axis_tdata_i[5*FieldW +: FieldW];
  assign in_fields.target_yaw        = s_axis_tdata_i[6*FieldW +: FieldW];
  assign in_fields.yaw_rate          = s_axis_tdata_i[7*FieldW +: FieldW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain  <= brcp_pkg::GainReset;
      cfg_q.limit <= brcp_pkg::LimitReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == brcp_pkg::REG_INTEGRAL_LIMIT) begin
        cfg_q.limit <= cfg_data_i[brcp_pkg::LimitW-1:0];
      end else begin
        cfg_q.gain[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  brcp_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .status_i   (status),
    .out_full_i (out_valid_q && !m_axis_tready_i),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  brcp_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_load_i (in_accept),
    .in_i      (in_fields),
    .cfg_i     (cfg_q),
    .ctrl_i    (ctrl),
    .status_o  (status),
    .left_o    (left_torque),
    .right_o   (right_torque)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {right_torque, left_torque};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("Pending result overwritten before its transaction.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready_o)
    else $error("Core ready again straight after accepting an item.");

  a_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !s_axis_tready_o)
    else $error("Result loaded while no item is being worked on.");
`endif

endmodule

// File: test/tb_balance_robot_cascade_pid_core.sv
// Self-checking testbench for balance_robot_cascade_pid_core: a bit-exact torque
// predictor checks every output transaction under random stalls and config changes.
// Depends on brcp_pkg and the core RTL only.
module tb_balance_robot_cascade_pid_core;

  localparam int One = 32'sh0001_0000;
  localparam bit [31:0] GainDefault [brcp_pkg::NumGains] = '{
    32'd80530637, 32'd13421773, 32'd13421773, 32'd134217728,
    32'd268435, 32'd26844, 32'd10737418
  };

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           s_tvalid = 1'b0;
  brcp_pkg::in_t  s_tdata = '0;
  logic           m_tready = 1'b0;
  logic           cfg_we = 1'b0;
  logic [2:0]     cfg_idx = '0;
  logic [31:0]    cfg_data = '0;
  logic           s_tready;
  logic           m_tvalid;
  logic [63:0]    m_tdata;

  bit [31:0]      gain_q28 [brcp_pkg::NumGains];
  bit [30:0]      limit_q16 = 31'd65536;
  longint         speed_acc = 0;
  longint         yaw_acc = 0;
  bit [63:0]      pending_torques [$];
  int unsigned    error_count = 0;
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_stall_pct = 0;
  int unsigned    rx_hold_cycles = 0;

  balance_robot_cascade_pid_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint scale(longint a, bit [31:0] g, int unsigned sh);
    longint hi;
    longint lo;
    hi = a * longint'({48'd0, g[31:16]});
    lo = a * longint'({48'd0, g[15:0]});
    return (hi + (lo >>> 16)) >>> (sh - 16);
  endfunction

  function automatic longint integrate(longint acc, longint err, longint band,
                                       bit [31:0] ki);
    longint lim;
    lim = longint'({33'd0, limit_q16}) <<< 16;
    if (err > -band && err < band) begin
      acc += (err * longint'({32'd0, ki})) >>> 12;
    end else begin
      acc = 0;
    end
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    return acc;
  endfunction

  function automatic bit [31:0] saturate(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void predict_torques(brcp_pkg::in_t s);
    longint verr;
    longint yerr;
    longint outer;
    longint pwm;
    longint pwm_yaw;
    if (s.target_speed == 0) speed_acc = 0;
    if (s.target_yaw == 0) yaw_acc = 0;
    verr = longint'(s.target_speed) -
           ((longint'(s.left_wheel_speed) + longint'(s.right_wheel_speed)) >>> 1);
    speed_acc = integrate(speed_acc, verr, 64'sd65536, gain_q28[brcp_pkg::REG_SPEED_KI]);
    outer = scale(verr, gain_q28[brcp_pkg::REG_SPEED_KP], 28) +
            scale(speed_acc, gain_q28[brcp_pkg::REG_SPEED_KI], 44);
    pwm = scale(longint'(s.pitch_angle) - outer, gain_q28[brcp_pkg::REG_PITCH_KP], 28) +
          scale(longint'(s.pitch_rate), gain_q28[brcp_pkg::REG_PITCH_KD], 28);
    yerr = longint'(s.yaw_angle) - longint'(s.target_yaw);
    yaw_acc = integrate(yaw_acc, yerr, 64'sd655360, gain_q28[brcp_pkg::REG_STEER_KI]);
    pwm_yaw = scale(yerr, gain_q28[brcp_pkg::REG_STEER_KP], 28) +
              scale(yaw_acc, gain_q28[brcp_pkg::REG_STEER_KI], 44) +
              scale(longint'(s.yaw_rate), gain_q28[brcp_pkg::REG_STEER_KD], 28);
    pending_torques.push_back({saturate(pwm - pwm_yaw), saturate(pwm + pwm_yaw)});
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : check_torques
    bit [63:0] want;
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_torques.size() == 0) begin
        report_mismatch($sformatf("unexpected output transaction %h", m_tdata));
      end else begin
        want = pending_torques.pop_front();
        if (m_tdata[31:0] !== want[31:0])
          report_mismatch($sformatf("left torque %h, predicted %h",
                                    m_tdata[31:0], want[31:0]));
        if (m_tdata[63:32] !== want[63:32])
          report_mismatch($sformatf("right torque %h, predicted %h",
                                    m_tdata[63:32], want[63:32]));
      end
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold_cycles - 1) @(posedge clk);
        rx_hold_cycles = 0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_reading(brcp_pkg::in_t s);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    do @(posedge clk); while (!s_tready);
    predict_torques(s);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_torques.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(brcp_pkg::reg_e r, bit [31:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (r == brcp_pkg::REG_INTEGRAL_LIMIT) limit_q16 = v[30:0];
    else gain_q28[r] = v;
    @(posedge clk);
  endtask

  function automatic brcp_pkg::in_t reading(int ts, int lw, int rw, int pa, int pr,
                                            int ya, int ty, int yr);
    brcp_pkg::in_t s;
    s.target_speed      = ts;
    s.left_wheel_speed  = lw;
    s.right_wheel_speed = rw;
    s.pitch_angle       = pa;
    s.pitch_rate        = pr;
    s.yaw_angle         = ya;
    s.target_yaw        = ty;
    s.yaw_rate          = yr;
    return s;
  endfunction

  function automatic int spread(int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  // Mostly near-balanced readings so that the speed integrator stays inside its band
  // and the yaw integrator mostly does, and both wind up; the rest is arbitrary data.
  function automatic brcp_pkg::in_t random_reading();
    brcp_pkg::in_t s;
    int ts;
    int ty;
    if ($urandom_range(99) < 22) begin
      return reading($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
    end
    ts = ($urandom_range(9) == 0) ? 0 : spread(1 << 20);
    ty = ($urandom_range(9) == 0) ? 0 : spread(1 << 22);
    s = reading(ts, ts + spread(1 << 16), ts + spread(1 << 16), spread(1 << 18),
                spread(1 << 20), ty + spread(12 << 16), ty, spread(1 << 20));
    return s;
  endfunction

  function automatic bit [31:0] pick_gain();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(32'h1000_0000);
    endcase
  endfunction

  function automatic bit [31:0] pick_limit();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(32'h0004_0000);
    endcase
  endfunction

  task automatic randomise_config();
    for (int r = 0; r < brcp_pkg::NumGains; r++) begin
      write_reg(brcp_pkg::reg_e'(r), pick_gain());
    end
    write_reg(brcp_pkg::REG_INTEGRAL_LIMIT, pick_limit());
  endtask

  task automatic test_reset_defaults();
    send_reading(reading(0, 0, 0, 0, 0, 0, 0, 0));
    send_reading(reading(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_reading(reading(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_reading(reading(3 * One, 2 * One + 1, 2 * One + 1, One, One, 5, 5 + One, 0));
    send_reading(reading(3 * One, 2 * One + 1, 2 * One + 1, One, One, 5, 5 + One, 0));
    send_reading(reading(3 * One, 2 * One, 2 * One, One, -One, 5 + 10 * One, 5, One));
    send_reading(reading(3 * One, 4 * One, 4 * One, 0, 0, 5 - 10 * One, 5, -One));
    send_reading(reading(5, 1, 0, 0, 0, 4 + 10 * One, 5, 0));
    send_reading(reading(5, -1, 0, 0, 0, 6 - 10 * One, 5, 0));
    send_reading(reading(0, One / 2, One / 4, One, 0, One, 0, 0));
    send_reading(reading(0, -One / 2, 0, -One, 0, -3 * One, 0, 0));
    send_reading(reading(One, One / 2, One, 0, 0, 2 * One, One, 0));
    stop_sending();
    wait_idle();
  endtask

  task automatic test_extreme_gains();
    for (int r = 0; r < brcp_pkg::NumGains; r++) begin
      write_reg(brcp_pkg::reg_e'(r), 32'hFFFF_FFFF);
    end
    write_reg(brcp_pkg::REG_INTEGRAL_LIMIT, 32'hFFFF_FFFF);
    send_reading(reading(One, One / 2, One / 2, One, One, 9 * One, One, One));
    send_reading(reading(One, One / 2, One / 2, One, One, 9 * One, One, One));
    send_reading(reading(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_reading(reading(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    stop_sending();
    wait_idle();
    write_reg(brcp_pkg::REG_INTEGRAL_LIMIT, One / 4);
    send_reading(reading(One, 1, 1, 0, 0, 9 * One, One, 0));
    send_reading(reading(-One, 1 - One, -One, 0, 0, -8 * One, One, 0));
    stop_sending();
    wait_idle();
  endtask

  task automatic test_zero_limit();
    write_reg(brcp_pkg::REG_SPEED_KP, 32'd0);
    write_reg(brcp_pkg::REG_PITCH_KP, GainDefault[brcp_pkg::REG_PITCH_KP]);
    write_reg(brcp_pkg::REG_STEER_KP, 32'd0);
    write_reg(brcp_pkg::REG_STEER_KI, 32'hFFFF_FFFF);
    write_reg(brcp_pkg::REG_INTEGRAL_LIMIT, 32'd0);
    send_reading(reading(One, One / 2, One / 2, One, One, 5 * One, One, One));
    send_reading(reading(-One, -One / 2, -One / 2, -One, One, -5 * One, -One, -One));
    send_reading(reading(One, 0, One / 2, 0, 0, 4 * One, One, 0));
    stop_sending();
    wait_idle();
  endtask

  task automatic test_random(int unsigned send_pct, int unsigned recv_pct,
                             int unsigned n);
    tx_idle_pct  = send_pct;
    rx_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 105 == 0) begin
        stop_sending();
        wait_idle();
        randomise_config();
      end
      send_reading(random_reading());
    end
    stop_sending();
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_cycles = 300;
    for (int i = 0; i < 12; i++) send_reading(random_reading());
    stop_sending();
    wait_idle();
  endtask

  initial begin
    gain_q28 = GainDefault;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extreme_gains();
    test_zero_limit();
    test_random(24, 45, 420);
    test_random(45, 24, 420);
    test_backpressure();
    test_random(0, 0, 420);
    repeat (32) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
